### sv/bvd_pkg.sv
// bvd_pkg: shared types and constants of the binary vote denoise filter.
// No dependencies; imported by every module of the block but bvd_row_mem.
package bvd_pkg;

	localparam int SIDE_W     = 12;
	localparam int THR_W      = 4;
	localparam int POS_W      = 11;
	localparam int SUM_W      = 4;
	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [SIDE_W-1:0] SIDE_RST = 12'd2048;
	localparam logic [THR_W-1:0]  THR_RST  = 4'd4;

	// window register bit positions
	localparam int WIN_W        = 6;
	localparam int WIN_RAW_UP_L = 0;  // raw (r-1, c-1)
	localparam int WIN_RAW_L1   = 1;  // raw (r, c-1)
	localparam int WIN_RAW_L2   = 2;  // raw (r, c-2)
	localparam int WIN_FLT_U2L2 = 3;  // filtered (r-2, c-2)
	localparam int WIN_FLT_U2L1 = 4;  // filtered (r-2, c-1)
	localparam int WIN_FLT_UL2  = 5;  // filtered (r-1, c-2)

	typedef enum logic {
		REG_SIDE = 1'b0,
		REG_THR  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic frame_start;
		logic pad;
		logic pixel;
	} in_item_t;

	typedef struct packed {
		logic             filtered;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_end;
		logic             run_last;
	} res_t;

	// up to two results handed from the core to the output buffer at once
	typedef struct packed {
		logic [1:0] n;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

### sv/binary_vote_denoise_filter_core.sv
// binary_vote_denoise_filter_core: top level, register port, input register.
// Depends on bvd_pkg, bvd_core, bvd_out_buf.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: pixel; tuser: pad, frame_start
//  m_*       out  m_tvalid/m_tready  tdata: filtered, out_row, out_col;
//                                    tlast: frame_end; tuser: run_last
//  apb       in   psel/penable       0x0 side, 0x4 vote_threshold
//
// One word per cycle in and one result per cycle out while m_tready stays high.
// The last-column word yields two results and the column-zero word after it
// none, so a row's words pass with no stall while m_tready stays high.
// Each word passes from the input register through the core into the result buffer.
// Reset clears position and window; the line stores have no clearing pass.
// A stalled master port backs up through the two-entry result buffer.
module binary_vote_denoise_filter_core #(
	parameter int MAX_SIDE = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bvd_pkg::IN_DATA_W-1:0] s_tdata,   // [0] pixel
	input  logic [bvd_pkg::IN_USER_W-1:0] s_tuser,   // [0] pad, [1] frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bvd_pkg::OUT_DATA_W-1:0] m_tdata,  // [0] filtered, [11:1] out_row,
	                                                 // [22:12] out_col
	output logic                          m_tlast,   // frame_end
	output logic                          m_tuser,   // run_last
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bvd_pkg::PADDR_W-1:0]   paddr,
	input  logic [bvd_pkg::PDATA_W-1:0]   pwdata,
	output logic [bvd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bvd_pkg::*;

	logic [SIDE_W-1:0] side_q;
	logic [THR_W-1:0]  thr_q;
	logic              s1_v;
	in_item_t          item_s1;
	logic              take, room;
	push_t             push;
	res_t              head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RST;
			thr_q  <= THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SIDE: side_q <= pwdata[SIDE_W-1:0];
				REG_THR:  thr_q  <= pwdata[THR_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SIDE: prdata = PDATA_W'(side_q);
			REG_THR:  prdata = PDATA_W'(thr_q);
		endcase
	end

	assign s_tready = !s1_v || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s_tready) begin
			s1_v <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.pixel       <= s_tdata[0];
			item_s1.pad         <= s_tuser[0];
			item_s1.frame_start <= s_tuser[1];
		end
	end

	bvd_core #(
		.MAX_SIDE (MAX_SIDE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item_v (s1_v),
		.item   (item_s1),
		.side   (side_q),
		.thr    (thr_q),
		.room   (room),
		.take   (take),
		.push   (push)
	);

	bvd_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.head   (head),
		.room   (room)
	);

	assign m_tdata = {1'b0, head.col, head.row, head.filtered};
	assign m_tlast = head.frame_end;
	assign m_tuser = head.run_last;

endmodule

### sv/bvd_row_mem.sv
// bvd_row_mem: one-bit-wide line memory, one write and one registered read port.
// A write to the address being read is forwarded to the read register.
module bvd_row_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= (we && waddr == raddr) ? wdata : mem[raddr];
	end

	assign rdata = rd_q;

endmodule

### sv/bvd_core.sv
// bvd_core: position counters, window register, line stores and vote logic.
// Depends on bvd_pkg and bvd_row_mem.
module bvd_core #(
	parameter int MAX_SIDE = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_v,
	input  bvd_pkg::in_item_t        item,
	input  logic [bvd_pkg::SIDE_W-1:0] side,
	input  logic [bvd_pkg::THR_W-1:0]  thr,
	input  logic                     room,
	output logic                     take,
	output bvd_pkg::push_t           push
);
	import bvd_pkg::*;

	localparam int AW   = $clog2(MAX_SIDE);
	localparam int RW   = $clog2(MAX_SIDE + 2);
	localparam int CMPW = (RW > SIDE_W) ? RW : SIDE_W;

	logic [RW-1:0]    row_q;
	logic [AW-1:0]    col_q;
	logic [WIN_W-1:0] win_q;
	logic             pend_v_q, pend_val_q;
	logic [AW-1:0]    pend_addr_q;
	logic             fix_v_q, fix_val_q;

	logic [CMPW-1:0]  side_x;
	logic [RW-1:0]    s, r, c_inc;
	logic [AW-1:0]    c, col_d;
	logic [WIN_W-1:0] wb, win_d;
	logic             ign, step, px, up_raw, up2, e1, e2, left, v2;
	logic             raw_rd, flt_mem_rd, flt_rd;
	logic [SUM_W-1:0] sum1, sum2;
	logic             flt_we, flt_wd;
	logic [AW-1:0]    flt_wa;
	logic [1:0]       n;
	res_t             res_a, res_b;

	// effective side: zero means one, clipped to the store depth
	always_comb begin
		side_x = CMPW'(side);
		if (side == '0) begin
			s = RW'(1);
		end else if (side_x > CMPW'(MAX_SIDE)) begin
			s = RW'(MAX_SIDE);
		end else begin
			s = RW'(side_x);
		end
	end

	always_comb begin
		r      = item.frame_start ? '0 : row_q;
		c      = item.frame_start ? '0 : col_q;
		ign    = (r > s) || (RW'(c) >= s);
		wb     = (c == '0) ? '0 : win_q;
		px     = (r < s) && !item.pad && item.pixel;
		up_raw = (r != '0) && raw_rd;
		up2    = (r >= RW'(2)) && flt_rd;

		sum1 = SUM_W'(wb[WIN_FLT_U2L2]) + SUM_W'(wb[WIN_FLT_U2L1]) + SUM_W'(up2)
		     + SUM_W'(wb[WIN_FLT_UL2]) + SUM_W'(wb[WIN_RAW_UP_L]) + SUM_W'(up_raw)
		     + SUM_W'(wb[WIN_RAW_L2]) + SUM_W'(wb[WIN_RAW_L1]) + SUM_W'(px);
		e1   = (r != '0) && (c != '0);
		left = e1 && (sum1 >= thr);

		// right edge: window columns beyond the image are zero
		sum2 = SUM_W'(wb[WIN_FLT_U2L1]) + SUM_W'(up2) + SUM_W'(left)
		     + SUM_W'(up_raw) + SUM_W'(wb[WIN_RAW_L1]) + SUM_W'(px);
		e2   = (r != '0) && (RW'(c) == s - RW'(1));
		v2   = sum2 >= thr;

		n = ign ? 2'd0 : (2'(e1) + 2'(e2));
		take = item_v && (n == 2'd0 || room);
		step = take && !ign;

		res_a.filtered  = left;
		res_a.row       = POS_W'(r - RW'(1));
		res_a.col       = POS_W'(c - AW'(1));
		res_a.frame_end = 1'b0;
		res_a.run_last  = !e2;

		res_b.filtered  = v2;
		res_b.row       = POS_W'(r - RW'(1));
		res_b.col       = POS_W'(c);
		res_b.frame_end = (r == s);
		res_b.run_last  = 1'b1;

		push.n      = take ? n : 2'd0;
		push.first  = e1 ? res_a : res_b;
		push.second = res_b;

		win_d               = '0;
		win_d[WIN_RAW_UP_L] = up_raw;
		win_d[WIN_RAW_L1]   = px;
		win_d[WIN_RAW_L2]   = wb[WIN_RAW_L1];
		win_d[WIN_FLT_U2L2] = wb[WIN_FLT_U2L1];
		win_d[WIN_FLT_U2L1] = up2;
		win_d[WIN_FLT_UL2]  = left;

		c_inc = RW'(c) + RW'(1);
		col_d = col_q;
		if (step) begin
			col_d = (c_inc >= s) ? '0 : AW'(c_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			win_q    <= '0;
			pend_v_q <= 1'b0;
			fix_v_q  <= 1'b0;
		end else begin
			if (step) begin
				col_q <= col_d;
				win_q <= win_d;
				if (c_inc >= s) begin
					row_q <= r + RW'(1);
				end else begin
					row_q <= r;
				end
			end
			pend_v_q <= step && e2;
			// right-edge value written next cycle but needed by the next read
			fix_v_q  <= step && e2 && (c == col_d);
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= c;
		pend_val_q  <= v2;
		fix_val_q   <= v2;
	end

	// right-edge write is deferred to the next cycle; the next item never writes then
	always_comb begin
		flt_we = pend_v_q || (step && e1);
		flt_wa = pend_v_q ? pend_addr_q : (c - AW'(1));
		flt_wd = pend_v_q ? pend_val_q : left;
	end

	assign flt_rd = fix_v_q ? fix_val_q : flt_mem_rd;

	bvd_row_mem #(
		.DEPTH (MAX_SIDE),
		.AW    (AW)
	) u_raw_mem (
		.clk   (clk),
		.we    (step),
		.waddr (c),
		.wdata (px),
		.raddr (col_d),
		.rdata (raw_rd)
	);

	bvd_row_mem #(
		.DEPTH (MAX_SIDE),
		.AW    (AW)
	) u_flt_mem (
		.clk   (clk),
		.we    (flt_we),
		.waddr (flt_wa),
		.wdata (flt_wd),
		.raddr (col_d),
		.rdata (flt_mem_rd)
	);

endmodule

### sv/bvd_out_buf.sv
// bvd_out_buf: two-entry result buffer between the core and the master port.
// Depends on bvd_pkg.
module bvd_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  bvd_pkg::push_t push,
	input  logic           ready,
	output logic           valid,
	output bvd_pkg::res_t  head,
	output logic           room
);
	import bvd_pkg::*;

	logic [1:0] cnt_q;
	res_t       res0_q, res1_q;
	logic       pop;

	assign valid = cnt_q != 2'd0;
	assign pop   = valid && ready;
	assign room  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign head  = res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push.n != 2'd0) begin
			cnt_q <= push.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			res0_q <= push.first;
			res1_q <= push.second;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

endmodule

### sv/bvd_checker.sv
// bvd_checker: port-level assertions for binary_vote_denoise_filter_core.
// Depends on bvd_pkg; attached to the top level by the bind below.
module bvd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bvd_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);
	import bvd_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("result word changed while stalled");

	// frame end is always the last result of its input word
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("frame_end without run_last");

	// a non-final result is followed at once by its right neighbor
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser |=> m_tvalid
		&& m_tdata[22:12] == $past(m_tdata[22:12]) + 11'd1
		&& m_tdata[11:1] == $past(m_tdata[11:1]))
		else $error("second result of a pair missing or misplaced");

	// input backpressure only comes from pending results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind binary_vote_denoise_filter_core bvd_checker u_bvd_checker (.*);
